>>> hdl/tace_pkg.sv
package tace_pkg;

  // Default sizes for the top-level parameters.
  localparam int REGISTER_COUNT_DEF = 8;
  localparam int PC_WIDTH_DEF       = 16;

  // Instruction word layout.
  localparam int WORD_W  = 32;
  localparam int OP_LSB  = 26;
  localparam int RS_LSB  = 21;
  localparam int RT_LSB  = 16;
  localparam int FLD_W   = 5;
  localparam int IMM_W   = 16;

  // Opcodes.
  localparam logic [5:0] OP_NOOP = 6'd0;
  localparam logic [5:0] OP_ALU  = 6'd1;
  localparam logic [5:0] OP_ADDI = 6'd2;
  localparam logic [5:0] OP_ANDI = 6'd3;
  localparam logic [5:0] OP_HALT = 6'd4;

  // ALU function codes.
  localparam logic [5:0] FN_ADD = 6'd0;
  localparam logic [5:0] FN_SUB = 6'd1;
  localparam logic [5:0] FN_AND = 6'd2;
  localparam logic [5:0] FN_OR  = 6'd3;
  localparam logic [5:0] FN_XOR = 6'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_STOPPED = 3'd2;
  localparam logic [2:0] ST_BAD_OP  = 3'd3;
  localparam logic [2:0] ST_BAD_FN  = 3'd4;
  localparam logic [2:0] ST_BAD_REG = 3'd5;

  typedef logic [WORD_W-1:0] word_t;

  // Outcome of executing one instruction, from the execute logic to the pipeline control.
  typedef struct packed {
    logic [2:0]       status;
    logic [FLD_W-1:0] dest;
    logic             written;
    word_t            value;
    logic             pc_inc;
    logic             count;
    logic             stop;
  } exec_res_t;

endpackage

>>> hdl/tace_ram.sv
module tace_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/tace_regfile.sv
module tace_regfile #(
  parameter int REG_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(REG_COUNT)-1:0] rd_addr_a,
  input  logic [$clog2(REG_COUNT)-1:0] rd_addr_b,
  input  logic                         wr_en,
  input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
  input  tace_pkg::word_t              wr_data,
  output tace_pkg::word_t              rd_data_a,
  output tace_pkg::word_t              rd_data_b
);

  import tace_pkg::*;

  localparam int IDX_W = $clog2(REG_COUNT);

  logic [REG_COUNT-1:0] valid_r;
  logic [IDX_W-1:0]     addr_a_r;
  logic [IDX_W-1:0]     addr_b_r;
  logic                 wb_valid_r;
  logic [IDX_W-1:0]     wb_addr_r;
  word_t                wb_data_r;
  word_t                q_a;
  word_t                q_b;

  // Two copies of the register file give the two read ports.
  tace_ram #(.DATA_W(WORD_W), .DEPTH(REG_COUNT)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_a),
    .rd_data (q_a)
  );

  tace_ram #(.DATA_W(WORD_W), .DEPTH(REG_COUNT)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_b),
    .rd_data (q_b)
  );

  // Written flags: an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      wb_valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
      wb_valid_r       <= 1'b1;
    end
  end

  // Hold the read addresses and the most recent write for forwarding.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_a_r <= rd_addr_a;
      addr_b_r <= rd_addr_b;
    end
    if (wr_en) begin
      wb_addr_r <= wr_addr;
      wb_data_r <= wr_data;
    end
  end

  // The write landing in the same cycle as a read is not seen by the RAM, so forward it.
  always_comb begin
    if (wb_valid_r && (wb_addr_r == addr_a_r)) begin
      rd_data_a = wb_data_r;
    end else if (valid_r[addr_a_r]) begin
      rd_data_a = q_a;
    end else begin
      rd_data_a = '0;
    end
    if (wb_valid_r && (wb_addr_r == addr_b_r)) begin
      rd_data_b = wb_data_r;
    end else if (valid_r[addr_b_r]) begin
      rd_data_b = q_b;
    end else begin
      rd_data_b = '0;
    end
  end

endmodule

>>> hdl/tace_exec.sv
module tace_exec #(
  parameter int REG_COUNT = 8
) (
  input  tace_pkg::word_t     instr,
  input  logic                stopped,
  input  tace_pkg::word_t     op_a,
  input  tace_pkg::word_t     op_b,
  output tace_pkg::exec_res_t res
);

  import tace_pkg::*;

  localparam logic [FLD_W:0] REG_LIMIT = (FLD_W + 1)'(REG_COUNT);

  logic [5:0]       op;
  logic [5:0]       fn;
  logic [FLD_W-1:0] rs;
  logic [FLD_W-1:0] rt;
  word_t            imm;
  logic             bad_reg;
  word_t            alu_out;

  assign op      = instr[OP_LSB +: 6];
  assign fn      = instr[5:0];
  assign rs      = instr[RS_LSB +: FLD_W];
  assign rt      = instr[RT_LSB +: FLD_W];
  assign imm     = {{(WORD_W - IMM_W){1'b0}}, instr[IMM_W-1:0]};
  assign bad_reg = ({1'b0, rs} >= REG_LIMIT) || ({1'b0, rt} >= REG_LIMIT);

  // Register-register and register-immediate arithmetic.
  always_comb begin
    case (op)
      OP_ALU: begin
        case (fn)
          FN_ADD:  alu_out = op_a + op_b;
          FN_SUB:  alu_out = op_a - op_b;
          FN_AND:  alu_out = op_a & op_b;
          FN_OR:   alu_out = op_a | op_b;
          default: alu_out = op_a ^ op_b;
        endcase
      end
      OP_ADDI: alu_out = op_a + imm;
      default: alu_out = op_a & imm;
    endcase
  end

  // Decode: status, writeback and the effect on the machine state.
  always_comb begin
    res         = '0;
    res.status  = ST_OK;
    res.pc_inc  = 1'b1;
    if (stopped) begin
      res.status = ST_STOPPED;
      res.pc_inc = 1'b0;
    end else begin
      case (op)
        OP_NOOP: begin
          res.count = 1'b1;
        end
        OP_HALT: begin
          res.status = ST_HALT;
          res.count  = 1'b1;
          res.stop   = 1'b1;
        end
        OP_ALU, OP_ADDI, OP_ANDI: begin
          if ((op == OP_ALU) && (fn > FN_XOR)) begin
            res.status = ST_BAD_FN;
            res.stop   = 1'b1;
          end else if (bad_reg) begin
            res.status = ST_BAD_REG;
            res.stop   = 1'b1;
          end else begin
            res.written = 1'b1;
            res.count   = 1'b1;
            res.value   = alu_out;
            res.dest    = (op == OP_ALU) ? rs : rt;
          end
        end
        default: begin
          res.status = ST_BAD_OP;
          res.stop   = 1'b1;
        end
      endcase
    end
  end

endmodule

>>> hdl/tiny_alu_cpu_execute_unit.sv
// Execute unit of a small eight-register CPU.
// The input channel (in_valid, in_ready, in_instruction_word) takes one fetched
// instruction word per item. The result channel (out_valid, out_ready and the
// out_ fields) returns exactly one result item per instruction, in order.
// The register file sits in a RAM with a registered read: an item's operands are
// read in the cycle it is accepted; it executes and writes back as it leaves execute.
// A write that lands while the following item's read is in flight is forwarded.
// out_valid rises once an item has left the execute stage for the output register;
// throughput is one item per cycle while the receiver keeps out_ready high, limited by
// the single write port of the register file.
// The output register lets the next item be accepted while a result waits.
// If the receiver stalls, the item in the execute stage holds and in_ready
// falls once both the execute stage and the output register are full.
// After a HALT or an error, later items get status "already stopped".
// Reset clears the program counter, cycle count, stop flag and the
// written flags of the register file, so all registers read as zero.
module tiny_alu_cpu_execute_unit #(
  parameter int REGISTER_COUNT = tace_pkg::REGISTER_COUNT_DEF,
  parameter int PC_WIDTH       = tace_pkg::PC_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_instruction_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [15:0]        out_next_pc,
  output logic [2:0]         out_dest_index,
  output logic               out_dest_written,
  output logic signed [31:0] out_alu_value,
  output logic [31:0]        out_cycle_total
);

  import tace_pkg::*;

  localparam int IDX_W = $clog2(REGISTER_COUNT);

  logic                accept;
  logic                out_free;
  logic                s1_adv;
  logic                s1_valid_r;
  word_t               s1_instr_r;
  logic [PC_WIDTH-1:0] pc_r;
  logic [PC_WIDTH-1:0] pc_nxt;
  logic [31:0]         cycle_r;
  logic [31:0]         cycle_nxt;
  logic                stopped_r;
  word_t               op_a;
  word_t               op_b;
  exec_res_t           res;
  logic                out_valid_r;
  logic [2:0]          out_status_r;
  logic [15:0]         out_next_pc_r;
  logic [2:0]          out_dest_r;
  logic                out_written_r;
  word_t               out_value_r;
  logic [31:0]         out_cycle_r;

  // Handshake: the execute stage moves on whenever the output register is free.
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign accept   = in_valid && in_ready;

  tace_regfile #(.REG_COUNT(REGISTER_COUNT)) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr_a (in_instruction_word[RS_LSB +: IDX_W]),
    .rd_addr_b (in_instruction_word[RT_LSB +: IDX_W]),
    .wr_en     (s1_adv && res.written),
    .wr_addr   (res.dest[IDX_W-1:0]),
    .wr_data   (res.value),
    .rd_data_a (op_a),
    .rd_data_b (op_b)
  );

  tace_exec #(.REG_COUNT(REGISTER_COUNT)) u_exec (
    .instr   (s1_instr_r),
    .stopped (stopped_r),
    .op_a    (op_a),
    .op_b    (op_b),
    .res     (res)
  );

  // Next machine state for the instruction in the execute stage.
  assign pc_nxt    = pc_r + {{(PC_WIDTH - 1){1'b0}}, res.pc_inc};
  assign cycle_nxt = cycle_r + {31'd0, res.count};

  // Pipeline control and machine state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      cycle_r     <= '0;
      stopped_r   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        pc_r        <= pc_nxt;
        cycle_r     <= cycle_nxt;
        stopped_r   <= stopped_r || res.stop;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr_r <= in_instruction_word;
    end
    if (s1_adv) begin
      out_status_r  <= res.status;
      out_next_pc_r <= 16'(pc_nxt);
      out_dest_r    <= res.dest[2:0];
      out_written_r <= res.written;
      out_value_r   <= res.value;
      out_cycle_r   <= cycle_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_next_pc      = out_next_pc_r;
  assign out_dest_index   = out_dest_r;
  assign out_dest_written = out_written_r;
  assign out_alu_value    = $signed(out_value_r);
  assign out_cycle_total  = out_cycle_r;

endmodule

>>> tb/tiny_alu_cpu_execute_unit_test.sv
`timescale 1ns / 1ps

module tiny_alu_cpu_execute_unit_test;

  import tace_pkg::*;

  // Fields of one result item, in the order the block reports them.
  typedef struct {
    logic [2:0]  status;
    logic [15:0] next_pc;
    logic [2:0]  dest_index;
    logic        dest_written;
    logic [31:0] alu_value;
    logic [31:0] cycle_total;
  } exec_result_t;

  // Shadow copy of the CPU state that predicts the result of every accepted instruction.
  class cpu_shadow;
    logic [31:0]  regs [REGISTER_COUNT_DEF];
    logic [15:0]  pc;
    logic [31:0]  retired;
    bit           halted;
    exec_result_t pending [$];
    int           failures;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc       = '0;
      retired  = '0;
      halted   = 1'b0;
      failures = 0;
    endfunction

    function void queue_result(logic [2:0] status, logic [2:0] dest, logic wrote,
                               logic [31:0] value);
      exec_result_t r;
      r.status       = status;
      r.next_pc      = pc;
      r.dest_index   = dest;
      r.dest_written = wrote;
      r.alu_value    = value;
      r.cycle_total  = retired;
      pending.push_back(r);
    endfunction

    // Executes one instruction on the shadow state and queues its result.
    function void retire(word_t w);
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] val;
      logic [2:0]  dst;
      op = w[OP_LSB +: 6];
      rs = w[RS_LSB +: FLD_W];
      rt = w[RT_LSB +: FLD_W];
      fn = w[5:0];
      if (halted) begin
        queue_result(ST_STOPPED, '0, 1'b0, '0);
        return;
      end
      // The fetch happened, so the program counter advances even on an error.
      pc = pc + 16'd1;
      if (op > OP_HALT) begin
        halted = 1'b1;
        queue_result(ST_BAD_OP, '0, 1'b0, '0);
      end else if (op == OP_ALU && fn > FN_XOR) begin
        halted = 1'b1;
        queue_result(ST_BAD_FN, '0, 1'b0, '0);
      end else if (op == OP_NOOP || op == OP_HALT) begin
        retired = retired + 32'd1;
        if (op == OP_HALT) begin
          halted = 1'b1;
          queue_result(ST_HALT, '0, 1'b0, '0);
        end else begin
          queue_result(ST_OK, '0, 1'b0, '0);
        end
      end else if (rs >= REGISTER_COUNT_DEF || rt >= REGISTER_COUNT_DEF) begin
        halted = 1'b1;
        queue_result(ST_BAD_REG, '0, 1'b0, '0);
      end else begin
        a = regs[rs[2:0]];
        b = regs[rt[2:0]];
        if (op == OP_ALU) begin
          case (fn)
            FN_ADD: val = a + b;
            FN_SUB: val = a - b;
            FN_AND: val = a & b;
            FN_OR:  val = a | b;
            default: val = a ^ b;
          endcase
          dst = rs[2:0];
        end else if (op == OP_ADDI) begin
          val = a + {16'h0000, w[15:0]};
          dst = rt[2:0];
        end else begin
          val = a & {16'h0000, w[15:0]};
          dst = rt[2:0];
        end
        regs[dst] = val;
        retired   = retired + 32'd1;
        queue_result(ST_OK, dst, 1'b1, val);
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    // Compares one accepted result item with the oldest prediction.
    function void compare(exec_result_t got);
      exec_result_t want;
      if (pending.size() == 0) begin
        failures++;
        $error("result item with no instruction outstanding");
        return;
      end
      want = pending.pop_front();
      check_field("status", want.status, got.status);
      check_field("next_pc", want.next_pc, got.next_pc);
      check_field("dest_index", want.dest_index, got.dest_index);
      check_field("dest_written", want.dest_written, got.dest_written);
      check_field("alu_value", want.alu_value, got.alu_value);
      check_field("cycle_total", want.cycle_total, got.cycle_total);
    endfunction
  endclass

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int TAIL_ITEMS   = 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        in_instruction_word;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_status;
  logic [15:0]        out_next_pc;
  logic [2:0]         out_dest_index;
  logic               out_dest_written;
  logic signed [31:0] out_alu_value;
  logic [31:0]        out_cycle_total;

  cpu_shadow shadow = new;
  bit        steady = 1'b0;
  int        cycle_count = 0;

  tiny_alu_cpu_execute_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_instruction_word (in_instruction_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_next_pc         (out_next_pc),
    .out_dest_index      (out_dest_index),
    .out_dest_written    (out_dest_written),
    .out_alu_value       (out_alu_value),
    .out_cycle_total     (out_cycle_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit; a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tiny_alu_cpu_execute_unit_test: FAIL");
      $finish;
    end
  end

  // Receiver stalls at random, except during steady stretches.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = steady || ($urandom_range(99) >= 25);
    end
  end

  // Every accepted result item goes to the scoreboard.
  always @(posedge clk) begin
    exec_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status       = out_status;
      got.next_pc      = out_next_pc;
      got.dest_index   = out_dest_index;
      got.dest_written = out_dest_written;
      got.alu_value    = out_alu_value;
      got.cycle_total  = out_cycle_total;
      shadow.compare(got);
    end
  end

  function automatic word_t alu_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                     logic [9:0] spare);
    return {OP_ALU, rs, rt, spare, fn};
  endfunction

  function automatic word_t imm_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                     logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // A well-formed instruction that keeps the CPU running.
  function automatic word_t random_instruction();
    int          pick;
    logic [15:0] imm;
    pick = $urandom_range(99);
    imm  = 16'($urandom);
    if ($urandom_range(9) == 0)
      imm = 16'hFFFF;
    else if ($urandom_range(9) == 0)
      imm = 16'h0000;
    if (pick < 15)
      return {OP_NOOP, 26'($urandom)};
    else if (pick < 60)
      return alu_word(6'($urandom_range(4)), 5'($urandom_range(7)),
                      5'($urandom_range(7)), 10'($urandom));
    else
      return imm_word((pick < 80) ? OP_ADDI : OP_ANDI, 5'($urandom_range(7)),
                      5'($urandom_range(7)), imm);
  endfunction

  // Offers one instruction item, called and returning at a falling edge.
  task automatic issue(input word_t w);
    while (!steady && $urandom_range(99) < 25) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid            = 1'b1;
    in_instruction_word = w;
    do @(posedge clk); while (!in_ready);
    shadow.retire(w);
    @(negedge clk);
  endtask

  initial begin
    word_t      last;
    logic [4:0] rs;
    logic [4:0] rt;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_instruction_word = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every non-stopping operation, operand and immediate extremes, wrap in both directions.
    issue({OP_NOOP, 26'h3FF_FFFF});
    issue(imm_word(OP_ADDI, 5'd0, 5'd1, 16'hFFFF));
    issue(imm_word(OP_ADDI, 5'd1, 5'd2, 16'hFFFF));
    issue(imm_word(OP_ADDI, 5'd0, 5'd0, 16'h0001));
    issue(alu_word(FN_SUB, 5'd5, 5'd0, '1));
    issue(alu_word(FN_ADD, 5'd5, 5'd0, '0));
    issue(alu_word(FN_SUB, 5'd5, 5'd0, 10'h2AA));
    issue(imm_word(OP_ADDI, 5'd5, 5'd5, 16'hFFFF));
    issue(alu_word(FN_SUB, 5'd3, 5'd1, 10'h155));
    issue(alu_word(FN_ADD, 5'd3, 5'd3, '0));
    issue(alu_word(FN_XOR, 5'd4, 5'd3, '1));
    issue(alu_word(FN_OR, 5'd4, 5'd2, '0));
    issue(alu_word(FN_AND, 5'd4, 5'd1, '1));
    issue(imm_word(OP_ADDI, 5'd3, 5'd6, 16'hFFFF));
    issue(imm_word(OP_ANDI, 5'd3, 5'd7, 16'hFFFF));
    issue(imm_word(OP_ANDI, 5'd3, 5'd7, 16'h0000));
    issue(imm_word(OP_ADDI, 5'd7, 5'd7, 16'h8000));
    issue(alu_word(FN_ADD, 5'd7, 5'd7, '0));
    issue(alu_word(FN_SUB, 5'd6, 5'd6, '0));
    issue(alu_word(FN_XOR, 5'd7, 5'd7, '1));
    issue({OP_NOOP, 26'h000_0000});

    // Random well-formed programs, with one stretch free of idling.
    for (int i = 0; i < RANDOM_ITEMS / 2; i++) begin
      steady = (i >= 400 && i < 600);
      issue(random_instruction());
    end
    steady = 1'b0;

    for (int i = 0; i < RANDOM_ITEMS / 2; i++)
      issue(random_instruction());

    // Only reset restarts the CPU, so one stopping instruction ends the program.
    case ($urandom_range(3))
      0: last = {OP_HALT, 26'($urandom)};
      1: last = {6'($urandom_range(63, 5)), 26'($urandom)};
      2: last = alu_word(6'($urandom_range(63, 5)), 5'($urandom), 5'($urandom),
                         10'($urandom));
      default: begin
        rs = 5'($urandom_range(31, 8));
        rt = 5'($urandom);
        if ($urandom_range(1) == 0) begin
          rt = rs;
          rs = 5'($urandom_range(7));
        end
        last = imm_word(6'($urandom_range(OP_ANDI, OP_ALU)), rs, rt,
                        {10'($urandom), 6'($urandom_range(4))});
      end
    endcase
    issue(last);

    // Anything after the stop must report the held state.
    for (int i = 0; i < TAIL_ITEMS; i++)
      issue($urandom);
    in_valid = 1'b0;

    while (shadow.pending.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (shadow.failures == 0)
      $display("tiny_alu_cpu_execute_unit_test: PASS");
    else
      $display("tiny_alu_cpu_execute_unit_test: FAIL");
    $finish;
  end

endmodule
